// ----- src/lfia_pkg.sv -----
// Package for the lowest free index allocator: sizes, codes and word types for the
// cell chain and top level; small helpers for the top level. No dependencies.
package lfia_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int INDEX_BITS = 16;
  localparam int FIELD_BITS = 16;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  localparam idx_t IDX_MAX = {INDEX_BITS{1'b1}};

  typedef enum logic {
    MODE_TAKE    = 1'b0,
    MODE_RECYCLE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_TAKEN    = 2'd0,
    ST_RECYCLED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    mode_t  mode;
    field_t index;
  } in_word_t;

  typedef struct packed {
    field_t  alloc_index;
    status_t status;
  } out_word_t;

  // Operation broadcast to every cell of the chain in the cycle a word is taken.
  typedef struct packed {
    logic take;
    logic insert;
    idx_t value;
  } cell_cmd_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic valid;
    logic shift;
    idx_t value;
  } cell_link_t;

  // Fits an input field to the index width: high bits dropped, or zeros added.
  function automatic idx_t field_to_idx(input field_t f);
    idx_t r;
    r = '0;
    for (int b = 0; b < INDEX_BITS; b++) begin
      if (b < FIELD_BITS) begin
        r[b] = f[b];
      end
    end
    return r;
  endfunction

  function automatic field_t idx_to_field(input idx_t v);
    field_t r;
    r = '0;
    for (int b = 0; b < FIELD_BITS; b++) begin
      if (b < INDEX_BITS) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

endpackage

// ----- src/lfia_cell.sv -----
// One cell of the sorted pool chain: holds one index and its valid flag.
// Depends on lfia_pkg for the command and link types.
module lfia_cell import lfia_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head,
  input  cell_cmd_t  cmd,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic valid;
  idx_t value;
  logic valid_next;
  idx_t value_next;
  logic shift;

  // This cell lies at or past the insertion point when it is empty or holds a
  // larger index; equal indices stay in front of the new one.
  assign shift = !valid || (value > cmd.value);

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (cmd.take) begin
      valid_next = right.valid;
      value_next = right.value;
    end else if (cmd.insert) begin
      valid_next = valid || left.valid || head;
      if (shift) begin
        value_next = left.shift ? left.value : cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= head;
      value <= '0;
    end else begin
      valid <= valid_next;
      value <= value_next;
    end
  end

  assign link.valid = valid;
  assign link.shift = shift;
  assign link.value = value;

endmodule

// ----- src/lowest_free_index_allocator_core.sv -----
// Lowest free index allocator. The free pool is kept in ascending order in a chain of
// POOL_DEPTH cells; every accepted word updates all cells at once, so one word is taken
// per clock while in_ready is high, and its result appears in the output register on
// the following cycle. in_ready is high whenever the output register is empty or being
// read in that cycle. Depends on lfia_pkg and lfia_cell.
module lowest_free_index_allocator_core import lfia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  cell_link_t links [POOL_DEPTH];
  cell_link_t lefts [POOL_DEPTH];
  cell_link_t rights[POOL_DEPTH];
  cell_cmd_t  cmd;
  logic       accept;
  logic       full;
  logic       last_one;
  logic       overflow;
  idx_t       got;
  idx_t       refill;
  out_word_t  result;
  out_word_t  out_data_next;
  logic       out_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign got      = links[0].value;
  assign full     = links[POOL_DEPTH-1].valid;
  assign last_one = !links[1].valid;
  assign overflow = last_one && (got == IDX_MAX);
  assign refill   = overflow ? IDX_MAX : got + idx_t'(1);

  assign cmd.take   = accept && (in_data.mode == MODE_TAKE);
  assign cmd.insert = accept && (in_data.mode == MODE_RECYCLE) && !full;
  assign cmd.value  = field_to_idx(in_data.index);

  // The head cell sees a refill word on its right when the pool holds one index.
  always_comb begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (i == 0) begin
        lefts[i] = '0;
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == POOL_DEPTH - 1) begin
        rights[i] = '0;
      end else begin
        rights[i] = links[i+1];
      end
    end
    if (last_one) begin
      rights[0].valid = 1'b1;
      rights[0].value = refill;
    end
  end

  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    lfia_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .head  ((g == 0) ? 1'b1 : 1'b0),
      .cmd   (cmd),
      .left  (lefts[g]),
      .right (rights[g]),
      .link  (links[g])
    );
  end

  always_comb begin
    result = '0;
    unique case (in_data.mode)
      MODE_TAKE: begin
        result.alloc_index = idx_to_field(got);
        result.status      = overflow ? ST_OVERFLOW : ST_TAKEN;
      end
      MODE_RECYCLE: begin
        result.status = full ? ST_DROPPED : ST_RECYCLED;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (accept) begin
      out_valid_next = 1'b1;
      out_data_next  = result;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

// ----- tb/sv/tb_lowest_free_index_allocator_core.sv -----
// Testbench for lowest_free_index_allocator_core: drives take and recycle words under varied
// idling, predicts every grant from its own sorted free pool and checks each output word.
// Depends on lfia_pkg and the allocator RTL.
module tb_lowest_free_index_allocator_core;
  import lfia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 800;

  // Sorted copy of the free pool and the grants still awaited from the block.
  class free_pool_model;
    idx_t      free_idx[POOL_DEPTH];
    int        free_count;
    out_word_t awaited_grants[$];
    int        errors;

    function new();
      foreach (free_idx[i]) free_idx[i] = '0;
      free_count = 1;
      errors = 0;
    endfunction

    function void note_request(in_word_t w);
      idx_t      got;
      idx_t      val;
      status_t   st;
      int        pos;
      out_word_t grant;
      got = '0;
      if (w.mode == MODE_TAKE) begin
        got = free_idx[0];
        for (int i = 1; i < free_count; i++) free_idx[i-1] = free_idx[i];
        free_count--;
        st = ST_TAKEN;
        // The pool never runs dry: the next index is put back, saturating at the top.
        if (free_count == 0) begin
          if (got == IDX_MAX) begin
            free_idx[0] = IDX_MAX;
            st = ST_OVERFLOW;
          end else begin
            free_idx[0] = got + idx_t'(1);
          end
          free_count = 1;
        end
      end else begin
        val = idx_t'(w.index);
        if (free_count >= POOL_DEPTH) begin
          st = ST_DROPPED;
        end else begin
          // Duplicates go after the copies already held.
          pos = 0;
          while (pos < free_count && free_idx[pos] <= val) pos++;
          for (int i = free_count; i > pos; i--) free_idx[i] = free_idx[i-1];
          free_idx[pos] = val;
          free_count++;
          st = ST_RECYCLED;
        end
      end
      grant.alloc_index = field_t'(got);
      grant.status = st;
      awaited_grants = {awaited_grants, grant};
    endfunction

    function void check_grant(out_word_t got);
      out_word_t want;
      if (awaited_grants.size() == 0) begin
        $display("%0t: unexpected word: alloc_index %h status %0d", $time,
                 got.alloc_index, got.status);
        errors++;
      end else begin
        want = awaited_grants.pop_front();
        if (got.alloc_index !== want.alloc_index) begin
          $display("%0t: alloc_index mismatch: expected %h, actual %h", $time,
                   want.alloc_index, got.alloc_index);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   want.status, got.status);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  free_pool_model pool_model;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_request;
  int             hold_left;
  int             cycles;

  lowest_free_index_allocator_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request && hold_left == 0) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) pool_model.note_request(in_data);
      if (out_valid && out_ready) pool_model.check_grant(out_data);
    end
  end

  task automatic send_word(input mode_t m, input field_t v);
    in_word_t w;
    w.mode = m;
    w.index = v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic take_word();
    send_word(MODE_TAKE, field_t'($urandom));
  endtask

  task automatic directed_words();
    take_word();                         // from reset: hands out 0, refills with 1
    take_word();
    send_word(MODE_RECYCLE, 16'hFFFF);
    take_word();
    take_word();                         // only the top index is left: overflow
    send_word(MODE_RECYCLE, 16'h0000);
    send_word(MODE_RECYCLE, 16'h0000);   // duplicate of a pooled index
    send_word(MODE_RECYCLE, 16'h5555);
    send_word(MODE_RECYCLE, 16'hAAAA);
    for (int i = 0; i < 12; i++) begin
      send_word(MODE_RECYCLE, field_t'(i * 1031 + 3));   // the last one meets a full pool
    end
    take_word();
    take_word();
  endtask

  task automatic random_words(input int count);
    int     take_pct;
    int     pick;
    field_t v;
    take_pct = 50;
    for (int n = 0; n < count; n++) begin
      // Bursts lean towards taking or recycling so the pool both fills and drains.
      if (n % 40 == 0) take_pct = 15 + 35 * $urandom_range(2);
      if ($urandom_range(99) < take_pct) begin
        take_word();
      end else begin
        pick = $urandom_range(99);
        if (pick < 55)      v = field_t'($urandom_range(15));
        else if (pick < 80) v = field_t'($urandom);
        else if (pick < 90) v = 16'hFFFF;
        else                v = field_t'($urandom_range(16'hFFFF, 16'hFFF0));
        send_word(MODE_RECYCLE, v);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cycles = 0;
    hold_request = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pool_model = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    directed_words();

    hold_request = 1'b1;
    random_words(RANDOM_WORDS / 4);
    send_idle_pct = 66;
    random_words(RANDOM_WORDS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    random_words(RANDOM_WORDS / 4);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    random_words(RANDOM_WORDS / 4);
    in_valid <= 1'b0;

    // Let the clock advance so that the last accepted word is surely noted before draining.
    @(posedge clk);
    while (pool_model.awaited_grants.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pool_model.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
